FILE: rtl/cmap_pkg.sv
// shared constants and codes for the chained hash map
// no dependencies
`default_nettype none
package cmap_pkg;
	localparam int CFG_W          = 7;
	localparam int BUCKET_RESET   = 17;
	localparam int DEF_BUCKETS    = 64;
	localparam int DEF_ENTRIES    = 256;
	localparam int DEF_HASH_SHIFT = 4;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_SET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;
endpackage
`default_nettype wire

FILE: rtl/chained_hash_map_word_keys.sv
// top level of the chained hash map: sequencer, bucket divider, node pool
// depends on cmap_pkg and cmap_ram
`default_nettype none
// One request at a time: start is taken while busy is low, and the result comes
// back on the result ports with a one-cycle done strobe that the receiver must
// take. A clear is answered straight from idle without raising busy. Other
// requests run a bit-serial bucket remainder over the 32 - HASH_SHIFT key bits
// (28 with default settings), read the chain head, step through the chain with
// an end test before each node, and then update. The remainder loop and the
// single read port of each node memory set the pace of a request.
// Node memories need no clearing pass after reset.
module chained_hash_map_word_keys
	import cmap_pkg::*;
#(
	parameter int BUCKETS    = DEF_BUCKETS,
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int HASH_SHIFT = DEF_HASH_SHIFT,
	localparam int NW = $clog2(ENTRIES + 1),
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [1:0]       req_type,
	input  wire logic [31:0]      key,
	input  wire logic [31:0]      new_value,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_data,
	output logic                  done,
	output logic                  found,
	output logic [31:0]           found_value,
	output logic [1:0]            status,
	output logic [NW-1:0]         entry_total
);
	localparam int DW    = 32 - HASH_SHIFT;
	localparam int CNT_W = $clog2(DW);
	localparam int BCAP  = (BUCKETS < 127) ? BUCKETS : 127;
	localparam logic [NW-1:0] NIL = NW'(ENTRIES);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_HEAD, S_HEAD_WAIT, S_WALK, S_CMP,
		S_ACT, S_ALLOC_WAIT, S_INSERT, S_RELINK
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [31:0]      key_q, nv_q, fval_q;
	logic [DW-1:0]    div_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CFG_W-1:0] cfg_q, rem_q, m_eff, rem_nx;
	logic [CFG_W:0]   rem_sh;
	logic [BW-1:0]    bucket_q;
	logic [BUCKETS-1:0] hvalid_q;
	logic [NW-1:0]    head_q, cur_q, prev_q, steps_q, nlink_q, new_q;
	logic [NW-1:0]    free_q, fresh_q, count_q, count_dec;
	logic             found_q, done_q;
	status_t          status_q;

	logic             h_we, l_we, k_we, v_we;
	logic [BW-1:0]    h_waddr;
	logic [NW-1:0]    h_wdata, l_wdata, h_rdata, l_rdata;
	logic [AW-1:0]    l_waddr, l_raddr, v_waddr;
	logic [31:0]      v_wdata, k_rdata, v_rdata;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign found       = found_q;
	assign found_value = fval_q;
	assign status      = status_q;
	assign entry_total = count_q;

	// remainder step and entry count decrement
	always_comb begin
		if (cfg_q == '0) begin
			m_eff = CFG_W'(1);
		end else if (cfg_q > CFG_W'(BCAP)) begin
			m_eff = CFG_W'(BCAP);
		end else begin
			m_eff = cfg_q;
		end
		rem_sh = {rem_q, div_q[DW-1]};
		if (rem_sh >= {1'b0, m_eff}) begin
			rem_nx = CFG_W'(rem_sh - {1'b0, m_eff});
		end else begin
			rem_nx = CFG_W'(rem_sh);
		end
		count_dec = (count_q != '0) ? count_q - NW'(1) : count_q;
	end

	// memory ports
	always_comb begin
		h_we    = 1'b0;
		h_waddr = bucket_q;
		h_wdata = new_q;
		l_we    = 1'b0;
		l_waddr = AW'(new_q);
		l_wdata = head_q;
		l_raddr = AW'(cur_q);
		k_we    = 1'b0;
		v_we    = 1'b0;
		v_waddr = AW'(new_q);
		v_wdata = nv_q;
		case (state_q)
			S_ACT: begin
				l_raddr = AW'(free_q);
				if (op_q == OP_SET && found_q) begin
					v_we    = 1'b1;
					v_waddr = AW'(cur_q);
				end
				if (op_q == OP_REMOVE && found_q) begin
					if (prev_q < NIL) begin
						l_we    = 1'b1;
						l_waddr = AW'(prev_q);
						l_wdata = nlink_q;
					end else begin
						h_we    = 1'b1;
						h_wdata = nlink_q;
					end
				end
			end
			S_INSERT: begin
				h_we = 1'b1;
				l_we = 1'b1;
				k_we = 1'b1;
				v_we = 1'b1;
			end
			S_RELINK: begin
				l_we    = 1'b1;
				l_waddr = AW'(cur_q);
				l_wdata = free_q;
			end
			default: begin
			end
		endcase
	end

	cmap_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_heads (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(bucket_q), .rdata(h_rdata)
	);
	cmap_ram #(.WIDTH(NW), .DEPTH(ENTRIES)) u_links (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);
	cmap_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_keys (
		.clk(clk), .we(k_we), .waddr(AW'(new_q)), .wdata(key_q),
		.raddr(AW'(cur_q)), .rdata(k_rdata)
	);
	cmap_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_values (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(AW'(cur_q)), .rdata(v_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cfg_q    <= CFG_W'(BUCKET_RESET);
			hvalid_q <= '0;
			free_q   <= NIL;
			fresh_q  <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			fval_q   <= '0;
			status_q <= ST_DONE;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (h_we) begin
				hvalid_q[bucket_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= op_t'(req_type);
						key_q    <= key;
						nv_q     <= new_value;
						div_q    <= key[31:HASH_SHIFT];
						rem_q    <= '0;
						cnt_q    <= '0;
						found_q  <= 1'b0;
						fval_q   <= '0;
						status_q <= ST_DONE;
						if (op_t'(req_type) == OP_CLEAR) begin
							hvalid_q <= '0;
							free_q   <= NIL;
							fresh_q  <= '0;
							count_q  <= '0;
							done_q   <= 1'b1;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= rem_nx;
					div_q <= div_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DW - 1)) begin
						bucket_q <= BW'(rem_nx);
						state_q  <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_HEAD_WAIT;
				end
				S_HEAD_WAIT: begin
					head_q  <= hvalid_q[bucket_q] ? h_rdata : NIL;
					cur_q   <= hvalid_q[bucket_q] ? h_rdata : NIL;
					prev_q  <= NIL;
					steps_q <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (cur_q >= NIL || steps_q == NIL) begin
						state_q <= S_ACT;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (k_rdata == key_q) begin
						found_q <= 1'b1;
						fval_q  <= v_rdata;
						nlink_q <= l_rdata;
						state_q <= S_ACT;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= l_rdata;
						steps_q <= steps_q + NW'(1);
						state_q <= S_WALK;
					end
				end
				S_ACT: begin
					case (op_q)
						OP_SET: begin
							if (found_q) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else if (free_q < NIL) begin
								new_q   <= free_q;
								state_q <= S_ALLOC_WAIT;
							end else if (fresh_q < NIL) begin
								new_q   <= fresh_q;
								fresh_q <= fresh_q + NW'(1);
								state_q <= S_INSERT;
							end else begin
								status_q <= ST_FULL;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						end
						OP_REMOVE: begin
							if (found_q) begin
								state_q <= S_RELINK;
							end else begin
								status_q <= ST_ABSENT;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						end
						default: begin
							status_q <= found_q ? ST_DONE : ST_ABSENT;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					endcase
				end
				S_ALLOC_WAIT: begin
					free_q  <= l_rdata;
					state_q <= S_INSERT;
				end
				S_INSERT: begin
					count_q <= count_q + NW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RELINK: begin
					count_q <= count_dec;
					if (count_dec == '0) begin
						hvalid_q <= '0;
						free_q   <= NIL;
						fresh_q  <= '0;
					end else begin
						free_q <= cur_q;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither started nor answered");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_DONE)
		else $error("found key reported with error status");
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> entry_total <= NIL)
		else $error("entry total beyond pool size");
`endif
endmodule
`default_nettype wire

FILE: rtl/cmap_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module cmap_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
